FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell, sorted_priority_queue and the testbench.
package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } spq_op_t;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic                       operation;
        logic signed [VALUE_W-1:0]  item_value;
        logic signed [PRIO_W-1:0]   item_priority;
    } spq_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]          status;
        logic signed [VALUE_W-1:0]  head_value;
        logic signed [PRIO_W-1:0]   head_priority;
        logic                       is_empty;
        logic [OCC_W-1:0]           occupancy;
    } spq_out_t;

    // per-beat command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } spq_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry, shifts left/right with its neighbors.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
#(
    parameter int PRIORITY_BITS = 16,
    parameter bit IS_HEAD       = 1'b0
)
(
    input  logic                      clk,
    input  spq_ctrl_t                 ctrl,
    input  logic                      occupied,
    input  logic [VALUE_W-1:0]        new_value,
    input  logic [PRIORITY_BITS-1:0]  new_priority,
    input  logic                      left_mark,
    input  logic [VALUE_W-1:0]        left_value,
    input  logic [PRIORITY_BITS-1:0]  left_priority,
    input  logic [VALUE_W-1:0]        right_value,
    input  logic [PRIORITY_BITS-1:0]  right_priority,
    output logic                      mark,
    output logic [VALUE_W-1:0]        value,
    output logic [PRIORITY_BITS-1:0]  priority_q
);

    logic [VALUE_W-1:0]       value_reg, value_next;
    logic [PRIORITY_BITS-1:0] prio_reg, prio_next;
    logic                     cmp;

    // head is displaced only by a strictly smaller priority
    always_comb
    begin
        if (IS_HEAD)
            cmp = $signed(prio_reg) > $signed(new_priority);
        else
            cmp = $signed(prio_reg) >= $signed(new_priority);
    end

    // mark: insertion point is at or before this slot
    assign mark = !occupied || cmp;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctrl.ins)
        begin
            if (left_mark)
            begin
                value_next = left_value;
                prio_next  = left_priority;
            end
            else if (mark)
            begin
                value_next = new_value;
                prio_next  = new_priority;
            end
        end
        else if (ctrl.del)
        begin
            value_next = right_value;
            prio_next  = right_priority;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value      = value_reg;
    assign priority_q = prio_reg;

endmodule

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue top level: a row of spq_cell slots plus count and result register.
// Depends on spq_pkg and spq_cell.
//
// One command per clock: busy stays low, and every beat on start produces one result
// in the next cycle, flagged by done for a single cycle. The receiver cannot stall, so
// results must be taken as they appear. Entries sit in a row of QUEUE_DEPTH cells kept
// sorted by ascending signed priority; every cell compares its own priority with the
// incoming one in parallel and an enqueue shifts the tail right by one slot, a dequeue
// shifts the whole row left. The compare in each cell plus the mark from its left
// neighbor sets the cycle time.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH   = 16,
    parameter int PRIORITY_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  spq_in_t  cmd,
    output logic     done,
    output spq_out_t result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     done_reg;
    spq_out_t                 result_reg, result_next;
    spq_ctrl_t                ctrl;
    logic                     accept;
    logic                     full, empty;
    logic [PRIORITY_BITS-1:0] new_prio;

    logic [QUEUE_DEPTH-1:0]   marks;
    logic [VALUE_W-1:0]       cell_value [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty  = count_reg == '0;

    assign ctrl.ins = accept && (cmd.operation == OP_ENQUEUE) && !full;
    assign ctrl.del = accept && (cmd.operation == OP_DEQUEUE) && !empty;

    // narrow priorities take the low bits; wide ones zero-extend the port field
    generate
        if (PRIORITY_BITS <= PRIO_W)
        begin : g_prio_narrow
            assign new_prio = cmd.item_priority[PRIORITY_BITS-1:0];
        end
        else
        begin : g_prio_wide
            assign new_prio = {{(PRIORITY_BITS-PRIO_W){1'b0}}, cmd.item_priority};
        end
    endgenerate

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                     l_mark;
            logic [VALUE_W-1:0]       l_value, r_value;
            logic [PRIORITY_BITS-1:0] l_prio, r_prio;

            if (gi == 0)
            begin : g_left_edge
                assign l_mark  = 1'b0;
                assign l_value = '0;
                assign l_prio  = '0;
            end
            else
            begin : g_left
                assign l_mark  = marks[gi-1];
                assign l_value = cell_value[gi-1];
                assign l_prio  = cell_prio[gi-1];
            end

            // the last slot's content after a dequeue is beyond the count
            if (gi == QUEUE_DEPTH - 1)
            begin : g_right_edge
                assign r_value = cell_value[gi];
                assign r_prio  = cell_prio[gi];
            end
            else
            begin : g_right
                assign r_value = cell_value[gi+1];
                assign r_prio  = cell_prio[gi+1];
            end

            spq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS),
                .IS_HEAD       (gi == 0)
            ) u_cell (
                .clk            (clk),
                .ctrl           (ctrl),
                .occupied       (count_reg > CNT_W'(gi)),
                .new_value      (cmd.item_value),
                .new_priority   (new_prio),
                .left_mark      (l_mark),
                .left_value     (l_value),
                .left_priority  (l_prio),
                .right_value    (r_value),
                .right_priority (r_prio),
                .mark           (marks[gi]),
                .value          (cell_value[gi]),
                .priority_q     (cell_prio[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + 1'b1;
        else if (ctrl.del)
            count_next = count_reg - 1'b1;
    end

    always_comb
    begin
        result_next               = '0;
        result_next.status        = STAT_OK;
        if (cmd.operation == OP_ENQUEUE && full)
            result_next.status = STAT_FULL;
        else if (cmd.operation == OP_DEQUEUE && empty)
            result_next.status = STAT_EMPTY;
        if (ctrl.del)
        begin
            result_next.head_value = cell_value[0];
            if (PRIORITY_BITS >= PRIO_W)
                result_next.head_priority = cell_prio[0][PRIO_W-1:0];
            else
                result_next.head_priority = PRIO_W'(cell_prio[0]);
        end
        result_next.is_empty  = count_next == '0;
        if (CNT_W >= OCC_W)
            result_next.occupancy = count_next[OCC_W-1:0];
        else
            result_next.occupancy = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: tb/sorted_priority_queue_test.sv
// Self-checking testbench for sorted_priority_queue: directed and random
// enqueue/dequeue beats checked against an in-bench model of the sorted row.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_test
    import spq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 1200;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct {
        spq_in_t c;
        bit      drain;   // hold this beat until every result is back
    } plan_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    spq_in_t  cmd;
    logic     done;
    spq_out_t result;

    plan_t    queued_cmds[$];
    spq_out_t owed_results[$];

    // mirror of the sorted row
    logic signed [VALUE_W-1:0] mirror_val[DEPTH];
    logic signed [PRIO_W-1:0]  mirror_pri[DEPTH];
    int                        mirror_count;

    logic beat_taken;
    int   sent_count;
    int   taken_count;
    int   total_cmds;
    int   cycle_count;
    int   mismatch_count;

    sorted_priority_queue i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // one enqueue or dequeue applied to the mirror, returns the result it must produce
    task automatic step_sorted_list(input spq_in_t c, output spq_out_t r);
        logic signed [PRIO_W-1:0] p;
        int pos;
        r = '0;
        r.status = STAT_OK;
        p = c.item_priority;
        if (c.operation == OP_ENQUEUE)
        begin
            if (mirror_count >= DEPTH)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                // head only gives way to a strictly smaller priority
                if (mirror_count == 0 || p < mirror_pri[0])
                begin
                    pos = 0;
                end
                else
                begin
                    pos = 1;
                    while (pos < mirror_count && mirror_pri[pos] < p)
                        pos++;
                end
                for (int i = mirror_count; i > pos; i--)
                begin
                    mirror_val[i] = mirror_val[i-1];
                    mirror_pri[i] = mirror_pri[i-1];
                end
                mirror_val[pos] = c.item_value;
                mirror_pri[pos] = p;
                mirror_count++;
            end
        end
        else
        begin
            if (mirror_count == 0)
            begin
                r.status = STAT_EMPTY;
            end
            else
            begin
                r.head_value    = mirror_val[0];
                r.head_priority = mirror_pri[0];
                for (int i = 1; i < mirror_count; i++)
                begin
                    mirror_val[i-1] = mirror_val[i];
                    mirror_pri[i-1] = mirror_pri[i];
                end
                mirror_count--;
            end
        end
        r.is_empty  = (mirror_count == 0);
        r.occupancy = mirror_count[OCC_W-1:0];
    endtask

    task automatic plan(input spq_op_t op, input logic [VALUE_W-1:0] v, input int p,
                        input bit drain);
        plan_t b;
        b.c.operation     = op;
        b.c.item_value    = v;
        b.c.item_priority = PRIO_W'(p);
        b.drain           = drain;
        queued_cmds.push_back(b);
    endtask

    function automatic spq_in_t random_cmd(input int enq_pct);
        spq_in_t c;
        int      pick;
        c.operation  = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
        c.item_value = $urandom;
        pick = $urandom_range(9);
        // mostly a narrow band so ties with head and non-head entries are common
        if (pick < 6)
            c.item_priority = PRIO_W'(int'($urandom_range(6)) - 3);
        else if (pick < 9)
            c.item_priority = PRIO_W'($urandom);
        else
            c.item_priority = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
        return c;
    endfunction

    // driver: new beats go out on the falling edge
    always @(negedge clk)
    begin
        plan_t nxt;
        logic  go;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!(start && !beat_taken))
        begin
            go = 1'b0;
            if (queued_cmds.size() > 0)
            begin
                if (queued_cmds[0].drain && owed_results.size() > 0)
                    go = 1'b0;
                else if (!(sent_count >= 500 && sent_count < 650) && $urandom_range(99) < 29)
                    go = 1'b0;
                else
                    go = 1'b1;
            end
            if (go)
            begin
                nxt = queued_cmds.pop_front();
                cmd <= nxt.c;
                sent_count++;
            end
            start <= go;
        end
    end

    // monitor and checker on the rising edge
    always @(posedge clk)
    begin
        spq_out_t want;
        spq_out_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            beat_taken <= rst_n && start && !busy;
            if (rst_n && done)
            begin
                got = result;
                if (owed_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing outstanding");
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  got.status, want.status));
                    if (got.head_value !== want.head_value)
                        report_mismatch($sformatf("head_value got %0d want %0d",
                                                  got.head_value, want.head_value));
                    if (got.head_priority !== want.head_priority)
                        report_mismatch($sformatf("head_priority got %0d want %0d",
                                                  got.head_priority, want.head_priority));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty got %0b want %0b",
                                                  got.is_empty, want.is_empty));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy got %0d want %0d",
                                                  got.occupancy, want.occupancy));
                end
            end
            if (rst_n && start && !busy)
            begin
                step_sorted_list(cmd, want);
                owed_results.push_back(want);
                taken_count++;
            end
        end
    end

    initial
    begin
        int n;
        int blk;
        int enq_pct;
        plan_t b;

        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        beat_taken     = 1'b0;
        mirror_count   = 0;
        sent_count     = 0;
        taken_count    = 0;
        cycle_count    = 0;
        mismatch_count = 0;

        // directed: empty dequeue, fill past full with ties and extremes, a few pops
        plan(OP_DEQUEUE, 32'h1234_5678, 77, 1'b0);
        plan(OP_ENQUEUE, 32'h7fff_ffff, 5, 1'b0);
        plan(OP_ENQUEUE, 32'h8000_0000, 5, 1'b0);       // ties head, lands behind it
        plan(OP_ENQUEUE, 32'h0000_0000, 3, 1'b0);       // new head
        plan(OP_ENQUEUE, 32'hffff_ffff, 3, 1'b0);       // ties head again
        plan(OP_ENQUEUE, 32'h0000_0011, 7, 1'b0);
        plan(OP_ENQUEUE, 32'h0000_0022, 7, 1'b0);       // ties a non-head, goes in front
        plan(OP_ENQUEUE, 32'h0000_0033, -32768, 1'b0);
        plan(OP_ENQUEUE, 32'h0000_0044, 32767, 1'b0);   // lands at the tail
        plan(OP_ENQUEUE, 32'h0000_0055, 0, 1'b0);
        plan(OP_ENQUEUE, 32'h0000_0066, -1, 1'b0);
        plan(OP_ENQUEUE, 32'h0000_0077, 1, 1'b0);
        plan(OP_ENQUEUE, 32'h0000_0088, 32767, 1'b0);
        plan(OP_ENQUEUE, 32'h0000_0099, -32768, 1'b0);  // ties the most negative head
        plan(OP_ENQUEUE, 32'h5555_aaaa, 100, 1'b0);
        plan(OP_ENQUEUE, 32'haaaa_5555, 5, 1'b0);
        plan(OP_ENQUEUE, 32'h0f0f_f0f0, 2, 1'b0);       // sixteenth entry
        plan(OP_ENQUEUE, 32'hdead_0001, -5, 1'b0);      // rejected, full
        plan(OP_DEQUEUE, 32'h0, 0, 1'b0);
        plan(OP_DEQUEUE, 32'hffff_ffff, -1, 1'b0);
        plan(OP_DEQUEUE, 32'h0, 0, 1'b0);

        // random: blocks that lean toward filling, draining or neither
        n = 0;
        while (n < RAND_ITEMS)
        begin
            blk = $urandom_range(60, 20);
            case ($urandom_range(2))
                0:       enq_pct = 80;
                1:       enq_pct = 20;
                default: enq_pct = 50;
            endcase
            for (int k = 0; k < blk && n < RAND_ITEMS; k++)
            begin
                b.c     = random_cmd(enq_pct);
                b.drain = (n % 300 == 0);
                queued_cmds.push_back(b);
                n++;
            end
        end
        total_cmds = queued_cmds.size();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (taken_count < total_cmds || owed_results.size() > 0);
        repeat (4) @(negedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
